/* sv/pjpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Print job priority queue package
// Shared constants, operation codes, the queue entry layout, the controller
// state type and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pjpq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int ID_W    = 16;
	localparam int PAGES_W = 16;
	localparam int COUNT_W = 32;
	localparam int QCOUNT_W = 5;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_TICK    = 1'b1
	} pjpq_op_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PAGES_W-1:0] total;
		logic [PAGES_W-1:0] left;
	} pjpq_entry_t;

	localparam int ENTRY_W = $bits(pjpq_entry_t);

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_UPDATE = 1'b1
	} pjpq_state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} pjpq_cmd_t;

	typedef struct packed {
		logic out_hold;
	} pjpq_status_t;

endpackage

/* sv/pjpq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pjpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/pjpq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Print job priority queue controller
// Takes one beat, then waits in the update state for the head entry to be read
// and commits the update once the output register can take the result.
// ----------------------------------------------------------------------------
module pjpq_ctrl
	import pjpq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  pjpq_status_t status,
	output pjpq_cmd_t    cmd
);

	pjpq_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!status.out_hold) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_UPDATE: begin
				cmd.commit = !status.out_hold;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

/* sv/pjpq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Print job priority queue datapath
// Holds the circular job store, the front and back pointers, the occupancy,
// the completion counters and the output register.
// ----------------------------------------------------------------------------
module pjpq_dp
	import pjpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pjpq_cmd_t           cmd,
	output pjpq_status_t        status,
	input  logic                opcode,
	input  logic [ID_W-1:0]     job_id,
	input  logic [PAGES_W-1:0]  pages,
	input  logic                urgent,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                accepted,
	output logic                job_done,
	output logic [ID_W-1:0]     done_job_id,
	output logic [PAGES_W-1:0]  done_pages,
	output logic [COUNT_W-1:0]  jobs_completed,
	output logic [COUNT_W-1:0]  pages_completed,
	output logic [QCOUNT_W-1:0] queue_count
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);

	// Captured beat.
	logic               op_q;
	logic [ID_W-1:0]    id_q;
	logic [PAGES_W-1:0] pg_q;
	logic               urg_q;

	logic [AW-1:0]      front_q, back_q;
	logic [OW-1:0]      occ_q;
	logic [COUNT_W-1:0] jobs_q, pages_sum_q;
	logic               out_valid_q;

	logic [ENTRY_W-1:0] rd_raw, wr_raw;
	pjpq_entry_t        head, wr_entry;
	logic               ram_we;
	logic [AW-1:0]      waddr;

	logic               is_tick, enq_ok, tick_ok, finish;
	logic [AW-1:0]      front_dec, front_inc, back_inc;
	logic [AW-1:0]      front_next, back_next;
	logic [OW-1:0]      occ_next;
	logic [COUNT_W-1:0] jobs_next, pages_sum_next;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			id_q  <= job_id;
			pg_q  <= pages;
			urg_q <= urgent;
		end
	end

	// The read port always follows the head, so the head entry is ready in
	// the cycle after a beat is taken.
	pjpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wr_raw),
		.raddr (front_q),
		.rdata (rd_raw)
	);

	assign head   = rd_raw;
	assign wr_raw = wr_entry;

	assign is_tick = (op_q == OP_TICK);
	assign enq_ok  = !is_tick && (occ_q < OW'(QUEUE_DEPTH));
	assign tick_ok = is_tick && (occ_q != '0);
	assign finish  = (head.left <= PAGES_W'(1));

	assign front_dec = (front_q == '0) ? AW'(QUEUE_DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(QUEUE_DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign back_inc  = (back_q == AW'(QUEUE_DEPTH - 1)) ? '0 : back_q + AW'(1);

	always_comb begin
		front_next     = front_q;
		back_next      = back_q;
		occ_next       = occ_q;
		jobs_next      = jobs_q;
		pages_sum_next = pages_sum_q;
		ram_we         = 1'b0;
		waddr          = front_q;
		wr_entry.id    = head.id;
		wr_entry.total = head.total;
		wr_entry.left  = head.left - PAGES_W'(1);
		if (enq_ok) begin
			ram_we         = 1'b1;
			wr_entry.id    = id_q;
			wr_entry.total = pg_q;
			wr_entry.left  = pg_q;
			occ_next       = occ_q + OW'(1);
			if (urg_q) begin
				front_next = front_dec;
				waddr      = front_dec;
			end else begin
				back_next = back_inc;
				waddr     = back_q;
			end
		end else if (tick_ok) begin
			if (finish) begin
				front_next     = front_inc;
				occ_next       = occ_q - OW'(1);
				jobs_next      = jobs_q + COUNT_W'(1);
				pages_sum_next = pages_sum_q + COUNT_W'(head.total);
			end else begin
				ram_we = 1'b1;
			end
		end
		ram_we = ram_we && cmd.commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			back_q      <= '0;
			occ_q       <= '0;
			jobs_q      <= '0;
			pages_sum_q <= '0;
		end else if (cmd.commit) begin
			front_q     <= front_next;
			back_q      <= back_next;
			occ_q       <= occ_next;
			jobs_q      <= jobs_next;
			pages_sum_q <= pages_sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			accepted        <= enq_ok;
			job_done        <= tick_ok && finish;
			done_job_id     <= (tick_ok && finish) ? head.id : '0;
			done_pages      <= (tick_ok && finish) ? head.total : '0;
			jobs_completed  <= jobs_next;
			pages_completed <= pages_sum_next;
			queue_count     <= QCOUNT_W'(occ_next);
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_hold = out_valid_q && out_stall;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(QUEUE_DEPTH))
		else $error("queue occupancy exceeds its depth");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("a committed item did not present a result");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(accepted && job_done))
		else $error("result reports both a stored job and a finished job");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !job_done) |-> (done_job_id == '0 && done_pages == '0))
		else $error("finished-job fields are nonzero without a finished job");

	a_no_commit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.commit)
		else $error("commit overwrote a result still waiting at the output");

endmodule

/* sv/print_job_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Print job priority queue
// Bounded deque of print jobs with urgent front insertion and page ticks.
// ----------------------------------------------------------------------------
// Each input beat is either an enqueue (urgent jobs go to the front, normal
// jobs to the back, a full queue drops the job) or a tick that prints one page
// of the head job and removes it when its remaining count reaches zero. Every
// beat yields exactly one result beat. For each item the beat is taken, the
// head entry comes out of the job store's registered read port in the next
// cycle and the update is committed once the output register is free; no new
// beat is taken before that commit. The result sits in an output register,
// so the next beat is taken while a result still waits; the commit waits only
// when that register is still full. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module print_job_priority_queue
	import pjpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [ID_W-1:0]     job_id,
	input  logic [PAGES_W-1:0]  pages,
	input  logic                urgent,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                accepted,
	output logic                job_done,
	output logic [ID_W-1:0]     done_job_id,
	output logic [PAGES_W-1:0]  done_pages,
	output logic [COUNT_W-1:0]  jobs_completed,
	output logic [COUNT_W-1:0]  pages_completed,
	output logic [QCOUNT_W-1:0] queue_count
);

	pjpq_cmd_t    cmd;
	pjpq_status_t status;

	pjpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pjpq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.opcode          (opcode),
		.job_id          (job_id),
		.pages           (pages),
		.urgent          (urgent),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.job_done        (job_done),
		.done_job_id     (done_job_id),
		.done_pages      (done_pages),
		.jobs_completed  (jobs_completed),
		.pages_completed (pages_completed),
		.queue_count     (queue_count)
	);

endmodule
